@@ sv/lspg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pixel generator package
// Shared widths, codes, configuration and job types, and the color wheel.
// ----------------------------------------------------------------------------
package lspg_pkg;

  localparam int LSPG_MAX_LEDS = 1024;

  localparam int IDX_W      = 10;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 11;
  localparam int EXT_W      = 7;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int ANG_W      = 9;
  localparam int RAT_W      = 18;
  localparam int PROD_W     = RAT_W + CH_W;

  localparam int QUEUE_DEPTH = 4;

  // floor(x / 225) = (x * DIV225_MUL) >> DIV225_SHIFT for x < 2**27
  localparam logic [27:0] DIV225_MUL   = 28'd152709949;
  localparam int          DIV225_SHIFT = 35;
  // floor(x / 5) = (x * DIV5_MUL) >> DIV5_SHIFT for x < 2**11
  localparam logic [11:0] DIV5_MUL     = 12'd3277;
  localparam int          DIV5_SHIFT   = 14;

  localparam logic [9:0] ANGLE_FULL = 10'd360;
  localparam logic [9:0] OFS_RED    = 10'd120;
  localparam logic [9:0] OFS_BLUE   = 10'd240;
  localparam logic [6:0] PCT_FULL   = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_RED       = 3'd1,
    REG_GREEN     = 3'd2,
    REG_BLUE      = 3'd3,
    REG_WHITE     = 3'd4,
    REG_EXTENT    = 3'd5,
    REG_DIRECTION = 3'd6,
    REG_COUNT     = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_STABLE   = 2'd0,
    MODE_GRADIENT = 2'd1,
    MODE_LOOP     = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    DIR_NEAR   = 2'd0,
    DIR_FAR    = 2'd1,
    DIR_CENTER = 2'd2,
    DIR_EDGES  = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    PIX_BLACK = 2'd0,
    PIX_BASE  = 2'd1,
    PIX_GRAD  = 2'd2,
    PIX_WHEEL = 2'd3
  } pix_class_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  white;
    logic [EXT_W-1:0] extent;
    logic [1:0]       direction;
    logic [CNT_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    pix_class_t       cls;
    logic [ANG_W-1:0] angle;
    logic [RAT_W-1:0] num;
    logic [RAT_W-1:0] den;
  } job_t;

  // Wheel entries from 240 on are all zero.
  localparam int WHEEL_LEN = 240;
  localparam logic [7:0] WHEEL_LUT [WHEEL_LEN] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd2, 8'd2, 8'd3,
    8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd11, 8'd12, 8'd13, 8'd15,
    8'd17, 8'd18, 8'd20, 8'd22, 8'd24, 8'd26, 8'd28, 8'd30, 8'd32, 8'd35,
    8'd37, 8'd39, 8'd42, 8'd44, 8'd47, 8'd49, 8'd52, 8'd55, 8'd58, 8'd60,
    8'd63, 8'd66, 8'd69, 8'd72, 8'd75, 8'd78, 8'd81, 8'd85, 8'd88, 8'd91,
    8'd94, 8'd97, 8'd101, 8'd104, 8'd107, 8'd111, 8'd114, 8'd117, 8'd121, 8'd124,
    8'd127, 8'd131, 8'd134, 8'd137, 8'd141, 8'd144, 8'd147, 8'd150, 8'd154, 8'd157,
    8'd160, 8'd163, 8'd167, 8'd170, 8'd173, 8'd176, 8'd179, 8'd182, 8'd185, 8'd188,
    8'd191, 8'd194, 8'd197, 8'd200, 8'd202, 8'd205, 8'd208, 8'd210, 8'd213, 8'd215,
    8'd217, 8'd220, 8'd222, 8'd224, 8'd226, 8'd229, 8'd231, 8'd232, 8'd234, 8'd236,
    8'd238, 8'd239, 8'd241, 8'd242, 8'd244, 8'd245, 8'd246, 8'd248, 8'd249, 8'd250,
    8'd251, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd253, 8'd253, 8'd252, 8'd251,
    8'd251, 8'd250, 8'd249, 8'd248, 8'd246, 8'd245, 8'd244, 8'd242, 8'd241, 8'd239,
    8'd238, 8'd236, 8'd234, 8'd232, 8'd231, 8'd229, 8'd226, 8'd224, 8'd222, 8'd220,
    8'd217, 8'd215, 8'd213, 8'd210, 8'd208, 8'd205, 8'd202, 8'd200, 8'd197, 8'd194,
    8'd191, 8'd188, 8'd185, 8'd182, 8'd179, 8'd176, 8'd173, 8'd170, 8'd167, 8'd163,
    8'd160, 8'd157, 8'd154, 8'd150, 8'd147, 8'd144, 8'd141, 8'd137, 8'd134, 8'd131,
    8'd127, 8'd124, 8'd121, 8'd117, 8'd114, 8'd111, 8'd107, 8'd104, 8'd101, 8'd97,
    8'd94, 8'd91, 8'd88, 8'd85, 8'd81, 8'd78, 8'd75, 8'd72, 8'd69, 8'd66,
    8'd63, 8'd60, 8'd58, 8'd55, 8'd52, 8'd49, 8'd47, 8'd44, 8'd42, 8'd39,
    8'd37, 8'd35, 8'd32, 8'd30, 8'd28, 8'd26, 8'd24, 8'd22, 8'd20, 8'd18,
    8'd17, 8'd15, 8'd13, 8'd12, 8'd11, 8'd9, 8'd8, 8'd7, 8'd6, 8'd5,
    8'd4, 8'd3, 8'd2, 8'd2, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0
  };

  function automatic logic [CH_W-1:0] wheel_at(input logic [ANG_W-1:0] idx);
    logic [CH_W-1:0] v;
    if (idx < ANG_W'(WHEEL_LEN)) begin
      v = WHEEL_LUT[idx[7:0]];
    end else begin
      v = '0;
    end
    return v;
  endfunction

endpackage

@@ sv/lspg_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel request channel
// Valid/ready channel carrying an LED index and a millisecond time.
// ----------------------------------------------------------------------------
interface lspg_in_if;
  logic                           valid;
  logic                           ready;
  logic [lspg_pkg::IDX_W-1:0]     led_index;
  logic [lspg_pkg::TIME_W-1:0]    time_ms;

  modport source(output valid, output led_index, output time_ms, input ready);
  modport sink(input valid, input led_index, input time_ms, output ready);
endinterface

@@ sv/lspg_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel response channel
// Valid/ready channel carrying one RGBW pixel.
// ----------------------------------------------------------------------------
interface lspg_out_if;
  logic                      valid;
  logic                      ready;
  logic [lspg_pkg::CH_W-1:0] red_out;
  logic [lspg_pkg::CH_W-1:0] green_out;
  logic [lspg_pkg::CH_W-1:0] blue_out;
  logic [lspg_pkg::CH_W-1:0] white_out;

  modport source(output valid, output red_out, output green_out, output blue_out,
                 output white_out, input ready);
  modport sink(input valid, input red_out, input green_out, input blue_out,
               input white_out, output ready);
endinterface

@@ sv/lspg_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface lspg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lspg_pkg::CFG_IDX_W-1:0]  index;
  logic [lspg_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ sv/lspg_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel generator front end
// Accepts requests, classifies them and reduces time and index to a wheel
// angle or a gradient ratio over four pipeline stages.
// ----------------------------------------------------------------------------
module lspg_front #(
  parameter int MAX_LEDS = lspg_pkg::LSPG_MAX_LEDS
) (
  input  logic           clk,
  input  logic           rst,
  input  lspg_pkg::cfg_t cfg,
  lspg_in_if.sink        pixel_req,
  input  logic           q_full,
  output logic           push,
  output lspg_pkg::job_t job
);
  import lspg_pkg::*;

  logic             adv;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] h;
  logic [CNT_W-1:0] i11;
  logic [CNT_W-1:0] k;
  pix_class_t       cls;
  logic [26:0]      x;
  logic [54:0]      prod_a;

  logic             va, vb, vc, vd;
  logic [IDX_W-1:0] a_i, b_i, c_i;
  logic [4:0]       a_tlo;
  logic [26:0]      a_x;
  logic [19:0]      a_q;
  logic [CNT_W-1:0] a_k;
  pix_class_t       a_cls, b_cls, c_cls, d_cls;

  logic [26:0]      q_mul;
  logic [7:0]       rem225;
  logic [RAT_W-1:0] den, dec;
  logic [12:0]      b_r7200;
  logic [RAT_W-1:0] b_den, b_dec;

  logic [10:0]      sec;
  logic [22:0]      tp;
  logic [RAT_W-1:0] num;
  logic [ANG_W-1:0] c_tick;
  logic [RAT_W-1:0] c_num, c_den;

  logic [10:0]      s;
  logic [10:0]      ang;
  logic [ANG_W-1:0] d_angle;
  logic [RAT_W-1:0] d_num, d_den;

  assign adv             = !q_full;
  assign pixel_req.ready = adv;

  assign n   = (32'(cfg.count) > 32'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : cfg.count;
  assign h   = n >> 1;
  assign i11 = {1'b0, pixel_req.led_index};

  always_comb begin
    case (dir_t'(cfg.direction))
      DIR_NEAR:   k = i11 + 1'b1;
      DIR_FAR:    k = n - i11;
      DIR_CENTER: k = (i11 >= h) ? (i11 - h + 1'b1) : (h - i11);
      DIR_EDGES:  k = (i11 < h) ? (i11 + 1'b1) : (n - i11);
      default:    k = i11 + 1'b1;
    endcase
  end

  always_comb begin
    if (i11 >= n) begin
      cls = PIX_BLACK;
    end else begin
      case (mode_t'(cfg.mode))
        MODE_LOOP:     cls = PIX_WHEEL;
        MODE_GRADIENT: cls = (cfg.extent == '0) ? PIX_BLACK : PIX_GRAD;
        default:       cls = PIX_BASE;
      endcase
    end
  end

  // t mod 7200 = ((t >> 5) mod 225) * 32 + t[4:0]
  assign x      = pixel_req.time_ms[31:5];
  assign prod_a = {28'd0, x} * {27'd0, DIV225_MUL};

  assign q_mul  = 27'({7'd0, a_q} * 27'd225);
  assign rem225 = 8'(a_x - q_mul);
  assign den    = RAT_W'({11'd0, cfg.extent} * {7'd0, n});
  assign dec    = RAT_W'({7'd0, a_k} * {11'd0, PCT_FULL});

  assign sec = b_r7200[12:2];
  assign tp  = {12'd0, sec} * {11'd0, DIV5_MUL};
  assign num = (b_den > b_dec) ? (b_den - b_dec) : '0;

  assign s = {2'd0, c_tick} + {1'b0, c_i};
  always_comb begin
    if (s >= {ANGLE_FULL, 1'b0} + {1'b0, ANGLE_FULL}) begin
      ang = s - ({ANGLE_FULL, 1'b0} + {1'b0, ANGLE_FULL});
    end else if (s >= {ANGLE_FULL, 1'b0}) begin
      ang = s - {ANGLE_FULL, 1'b0};
    end else if (s >= {1'b0, ANGLE_FULL}) begin
      ang = s - {1'b0, ANGLE_FULL};
    end else begin
      ang = s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else if (adv) begin
      va <= pixel_req.valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_i     <= pixel_req.led_index;
      a_tlo   <= pixel_req.time_ms[4:0];
      a_x     <= x;
      a_q     <= prod_a[54:DIV225_SHIFT];
      a_k     <= k;
      a_cls   <= cls;

      b_i     <= a_i;
      b_r7200 <= {rem225, a_tlo};
      b_den   <= den;
      b_dec   <= dec;
      b_cls   <= a_cls;

      c_i     <= b_i;
      c_tick  <= tp[22:DIV5_SHIFT];
      c_num   <= num;
      c_den   <= b_den;
      c_cls   <= b_cls;

      d_angle <= ANG_W'(ang);
      d_num   <= c_num;
      d_den   <= c_den;
      d_cls   <= c_cls;
    end
  end

  assign push      = vd && adv;
  assign job.cls   = d_cls;
  assign job.angle = d_angle;
  assign job.num   = d_num;
  assign job.den   = d_den;

endmodule

@@ sv/lspg_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel job queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module lspg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lspg_pkg::job_t wr,
  input  logic           pop,
  output lspg_pkg::job_t rd,
  output logic           full,
  output logic           empty
);
  import lspg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  job_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wp, rp;
  logic [CNT_QW-1:0] cnt;

  assign full  = (cnt == CNT_QW'(QUEUE_DEPTH));
  assign empty = (cnt == '0);
  assign rd    = entries[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= wr;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> cnt == $past(cnt) + 1'b1)
    else $error("queue count did not advance on push");
  a_cnt_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> cnt == $past(cnt) - 1'b1)
    else $error("queue count did not drop on pop");

endmodule

@@ sv/lspg_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel generator back end
// Scales the base color through an 8-stage restoring divider, looks up the
// color wheel and holds the result in the output register.
// ----------------------------------------------------------------------------
module lspg_back (
  input  logic           clk,
  input  logic           rst,
  input  lspg_pkg::cfg_t cfg,
  input  lspg_pkg::job_t head,
  input  logic           q_empty,
  output logic           pop,
  lspg_out_if.source     pixel_rsp
);
  import lspg_pkg::*;

  localparam int NSTG = CH_W;

  typedef struct packed {
    pix_class_t                  cls;
    logic [ANG_W-1:0]            ir;
    logic [ANG_W-1:0]            ig;
    logic [ANG_W-1:0]            ib;
    logic [RAT_W-1:0]            den;
    logic [3:0][PROD_W-1:0]      rem;
    logic [3:0][CH_W-1:0]        quo;
  } dv_t;

  logic                 adv;
  logic [3:0][CH_W-1:0] base;
  logic [9:0]           sum_r, sum_b;
  dv_t                  p_nx, p;
  logic                 v_p;
  dv_t                  src [NSTG];
  dv_t                  nx  [NSTG];
  dv_t                  st  [NSTG];
  logic [NSTG-1:0]      vs;

  assign adv  = !pixel_rsp.valid || pixel_rsp.ready;
  assign pop  = adv && !q_empty;
  assign base = {cfg.white, cfg.blue, cfg.green, cfg.red};

  assign sum_r = {1'b0, head.angle} + OFS_RED;
  assign sum_b = {1'b0, head.angle} + OFS_BLUE;

  always_comb begin
    p_nx     = '0;
    p_nx.cls = head.cls;
    p_nx.ig  = head.angle;
    p_nx.ir  = ANG_W'((sum_r >= ANGLE_FULL) ? (sum_r - ANGLE_FULL) : sum_r);
    p_nx.ib  = ANG_W'((sum_b >= ANGLE_FULL) ? (sum_b - ANGLE_FULL) : sum_b);
    p_nx.den = head.den;
    for (int c = 0; c < 4; c++) begin
      p_nx.rem[c] = PROD_W'({10'd0, base[c]} * {8'd0, head.num});
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < NSTG; j++) begin : g_div
    localparam int BIT = NSTG - 1 - j;
    logic [PROD_W-1:0] dsh;

    if (j == 0) begin : g_first
      assign src[j] = p;
    end else begin : g_rest
      assign src[j] = st[j-1];
    end

    assign dsh = PROD_W'({8'd0, src[j].den} << BIT);

    always_comb begin
      nx[j] = src[j];
      for (int c = 0; c < 4; c++) begin
        if (src[j].rem[c] >= dsh) begin
          nx[j].rem[c]      = src[j].rem[c] - dsh;
          nx[j].quo[c][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[j] <= nx[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p             <= 1'b0;
      vs              <= '0;
      pixel_rsp.valid <= 1'b0;
    end else if (adv) begin
      v_p             <= !q_empty;
      vs              <= {vs[NSTG-2:0], v_p};
      pixel_rsp.valid <= vs[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p <= p_nx;
      case (st[NSTG-1].cls)
        PIX_BASE: begin
          pixel_rsp.red_out   <= cfg.red;
          pixel_rsp.green_out <= cfg.green;
          pixel_rsp.blue_out  <= cfg.blue;
          pixel_rsp.white_out <= cfg.white;
        end
        PIX_GRAD: begin
          pixel_rsp.red_out   <= st[NSTG-1].quo[0];
          pixel_rsp.green_out <= st[NSTG-1].quo[1];
          pixel_rsp.blue_out  <= st[NSTG-1].quo[2];
          pixel_rsp.white_out <= st[NSTG-1].quo[3];
        end
        PIX_WHEEL: begin
          pixel_rsp.red_out   <= wheel_at(st[NSTG-1].ir);
          pixel_rsp.green_out <= wheel_at(st[NSTG-1].ig);
          pixel_rsp.blue_out  <= wheel_at(st[NSTG-1].ib);
          pixel_rsp.white_out <= '0;
        end
        default: begin
          pixel_rsp.red_out   <= '0;
          pixel_rsp.green_out <= '0;
          pixel_rsp.blue_out  <= '0;
          pixel_rsp.white_out <= '0;
        end
      endcase
    end
  end

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vs) && $stable(v_p))
    else $error("divider pipeline moved while output stalled");
  a_pop_loads: assert property (@(posedge clk) disable iff (rst) pop |=> v_p)
    else $error("popped request did not enter the back end");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    adv && vs[NSTG-1] |=> pixel_rsp.valid)
    else $error("finished pixel lost at output register");

endmodule

@@ sv/led_strip_effect_pixel_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip effect pixel generator
// Returns the RGBW value of one LED under the stable, gradient or color
// loop effect.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_wr    - register writes (index 0..7: mode, red, green, blue, white,
//               extent, direction, count); always ready. Write only while
//               no request is in flight.
//   pixel_req - one request per LED: led_index and time_ms.
//   pixel_rsp - one RGBW response per request, in request order.
// Path: a request, once taken, passes through these registers:
//   four front stages, one queue slot, a scaling stage, eight divider
//   stages (one quotient bit each) and the output register.
// Throughput: one request per cycle while pixel_rsp is taken.
// Stall: when pixel_rsp is not taken, the back end and output hold; the
//   front end keeps taking requests until the 4-entry queue fills, then
//   drops pixel_req.ready.
// Reset: all in-flight requests are discarded and registers return to
//   mode 0, colors 0, extent 100, direction 0, count 1.
// ----------------------------------------------------------------------------
module led_strip_effect_pixel_generator_unit #(
  parameter int MAX_LEDS = lspg_pkg::LSPG_MAX_LEDS
) (
  input logic         clk,
  input logic         rst,
  lspg_cfg_if.sink    cfg_wr,
  lspg_in_if.sink     pixel_req,
  lspg_out_if.source  pixel_rsp
);
  import lspg_pkg::*;

  cfg_t cfg;
  logic push, pop, q_full, q_empty;
  job_t wr_job, head;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= MODE_STABLE;
      cfg.red       <= '0;
      cfg.green     <= '0;
      cfg.blue      <= '0;
      cfg.white     <= '0;
      cfg.extent    <= PCT_FULL;
      cfg.direction <= DIR_NEAR;
      cfg.count     <= CNT_W'(1);
    end else if (cfg_wr.valid) begin
      case (reg_idx_t'(cfg_wr.index))
        REG_MODE:      cfg.mode      <= cfg_wr.data[1:0];
        REG_RED:       cfg.red       <= cfg_wr.data[CH_W-1:0];
        REG_GREEN:     cfg.green     <= cfg_wr.data[CH_W-1:0];
        REG_BLUE:      cfg.blue      <= cfg_wr.data[CH_W-1:0];
        REG_WHITE:     cfg.white     <= cfg_wr.data[CH_W-1:0];
        REG_EXTENT:    cfg.extent    <= cfg_wr.data[EXT_W-1:0];
        REG_DIRECTION: cfg.direction <= cfg_wr.data[1:0];
        REG_COUNT:     cfg.count     <= cfg_wr.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  lspg_front #(.MAX_LEDS(MAX_LEDS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pixel_req (pixel_req),
    .q_full    (q_full),
    .push      (push),
    .job       (wr_job)
  );

  lspg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr    (wr_job),
    .pop   (pop),
    .rd    (head),
    .full  (q_full),
    .empty (q_empty)
  );

  lspg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .pixel_rsp (pixel_rsp)
  );

endmodule
